/* hw/rtl/quaternion_to_euler_core_assert.svh */
// Assertion macros shared by the quaternion to Euler checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef QUATERNION_TO_EULER_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define Q2E_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion_to_euler_core assertion failed");

// Condition that holds on every clock edge outside reset.
`define Q2E_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("quaternion_to_euler_core assertion failed");

`endif

/* hw/rtl/q2e_pkg.sv */
// Constants and arctangent table for the quaternion to Euler core.
// No dependencies.
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  // bits of the integer square root of a Q.28 value
  localparam int SQRT_STEPS       = 15;
  // products, sums, pre-rotation and output stages around the loops
  localparam int FIXED_STAGES     = SQRT_STEPS + 4;
  // angle accumulator width, units of 2^-20 rad
  localparam int ZW               = 24;
  localparam int HALF_PI_U        = 1647099;
  localparam int ROLL_LIM         = 25736;
  localparam int PITCH_LIM        = 12868;

  // atan(2^-i) rounded to nearest, units of 2^-20 rad
  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:       v = ZW'(823550);
      1:       v = ZW'(486170);
      2:       v = ZW'(256879);
      3:       v = ZW'(130396);
      4:       v = ZW'(65451);
      5:       v = ZW'(32757);
      6:       v = ZW'(16383);
      7:       v = ZW'(8192);
      8:       v = ZW'(4096);
      9:       v = ZW'(2048);
      10:      v = ZW'(1024);
      11:      v = ZW'(512);
      12:      v = ZW'(256);
      13:      v = ZW'(128);
      14:      v = ZW'(64);
      15:      v = ZW'(32);
      16:      v = ZW'(16);
      17:      v = ZW'(8);
      18:      v = ZW'(4);
      19:      v = ZW'(2);
      20:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/quaternion_to_euler_core.sv */
// Throughput: one item every cycle; busy is always low, the receiver cannot stall.
// The pipeline holds the 15-stage square root pipeline and the unrolled
// CORDIC stages. Reset (synchronous, rst) clears all valid bits.
`timescale 1ns / 1ps
module quaternion_to_euler_core #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               strobe,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  localparam int N   = (CORDIC_STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN
                                                          : CORDIC_STEPS;
  localparam int SQ  = q2e_pkg::SQRT_STEPS;
  localparam int LAT = N + q2e_pkg::FIXED_STAGES;
  localparam int ZW  = q2e_pkg::ZW;
  localparam int CW  = 38;
  localparam logic signed [33:0] ONE28 = 34'sd268435456;

  assign busy = 1'b0;

  // valid bits travel with the items
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end
  assign strobe = vld[LAT-1];

  // stage 1: products
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_xz;
  always_ff @(posedge clk) begin
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
    p_wy <= quat_w * quat_y;
    p_xz <= quat_x * quat_z;
  end

  // stage 2: product sums, pitch argument saturated to [-1, 1]
  logic signed [33:0] sr_c, cr_c, sy_c, cy_c, s_raw, s_sat, sa_c, sb_c;
  always_comb begin
    sr_c  = (34'(p_wx) + 34'(p_yz)) <<< 1;
    cr_c  = ONE28 - ((34'(p_xx) + 34'(p_yy)) <<< 1);
    sy_c  = (34'(p_wz) + 34'(p_xy)) <<< 1;
    cy_c  = ONE28 - ((34'(p_yy) + 34'(p_zz)) <<< 1);
    s_raw = (34'(p_wy) - 34'(p_xz)) <<< 1;
    priority if (s_raw > ONE28) begin
      s_sat = ONE28;
    end else if (s_raw < -ONE28) begin
      s_sat = -ONE28;
    end else begin
      s_sat = s_raw;
    end
    sa_c = ONE28 + s_sat;
    sb_c = ONE28 - s_sat;
  end

  // square root pipeline, one root bit per stage; roll/yaw terms ride along
  logic [29:0]        sq_v   [2][0:SQ];
  logic [17:0]        sq_rem [2][0:SQ];
  logic [14:0]        sq_root[2][0:SQ];
  logic signed [33:0] dl_sr[0:SQ], dl_cr[0:SQ], dl_sy[0:SQ], dl_cy[0:SQ];

  always_ff @(posedge clk) begin
    sq_v[0][0]    <= sa_c[29:0];
    sq_v[1][0]    <= sb_c[29:0];
    sq_rem[0][0]  <= '0;
    sq_rem[1][0]  <= '0;
    sq_root[0][0] <= '0;
    sq_root[1][0] <= '0;
    dl_sr[0] <= sr_c;
    dl_cr[0] <= cr_c;
    dl_sy[0] <= sy_c;
    dl_cy[0] <= cy_c;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    for (genvar h = 0; h < 2; h++) begin : g_half
      logic [17:0] rem_sh, trial;
      always_comb begin
        rem_sh = {sq_rem[h][k][15:0], sq_v[h][k][29:28]};
        trial  = {1'b0, sq_root[h][k], 2'b01};
      end
      always_ff @(posedge clk) begin
        sq_v[h][k+1] <= {sq_v[h][k][27:0], 2'b00};
        if (rem_sh >= trial) begin
          sq_rem[h][k+1]  <= rem_sh - trial;
          sq_root[h][k+1] <= {sq_root[h][k][13:0], 1'b1};
        end else begin
          sq_rem[h][k+1]  <= rem_sh;
          sq_root[h][k+1] <= {sq_root[h][k][13:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      dl_sr[k+1] <= dl_sr[k];
      dl_cr[k+1] <= dl_cr[k];
      dl_sy[k+1] <= dl_sy[k];
      dl_cy[k+1] <= dl_cy[k];
    end
  end

  // CORDIC inputs: 0 roll, 1 pitch, 2 yaw
  logic signed [CW-1:0] in_x[3], in_y[3];
  always_comb begin
    in_y[0] = CW'(dl_sr[SQ]);
    in_x[0] = CW'(dl_cr[SQ]);
    in_y[1] = CW'({1'b0, sq_root[0][SQ]});
    in_x[1] = CW'({1'b0, sq_root[1][SQ]});
    in_y[2] = CW'(dl_sy[SQ]);
    in_x[2] = CW'(dl_cy[SQ]);
  end

  logic signed [CW-1:0] cx[3][0:N], cy[3][0:N];
  logic signed [ZW-1:0] cz[3][0:N];
  logic                 czero[3][0:N];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    // pre-rotation into the right half plane
    always_ff @(posedge clk) begin
      czero[a][0] <= (in_x[a] == '0) && (in_y[a] == '0);
      if (in_x[a] < 0) begin
        if (in_y[a] >= 0) begin
          cx[a][0] <= in_y[a];
          cy[a][0] <= -in_x[a];
          cz[a][0] <= ZW'(q2e_pkg::HALF_PI_U);
        end else begin
          cx[a][0] <= -in_y[a];
          cy[a][0] <= in_x[a];
          cz[a][0] <= -ZW'(q2e_pkg::HALF_PI_U);
        end
      end else begin
        cx[a][0] <= in_x[a];
        cy[a][0] <= in_y[a];
        cz[a][0] <= '0;
      end
    end

    // vectoring iterations
    for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [CW-1:0] dx, dy;
      always_comb begin
        dx = cy[a][i] >>> i;
        dy = cx[a][i] >>> i;
      end
      always_ff @(posedge clk) begin
        czero[a][i+1] <= czero[a][i];
        if (cy[a][i] >= 0) begin
          cx[a][i+1] <= cx[a][i] + dx;
          cy[a][i+1] <= cy[a][i] - dy;
          cz[a][i+1] <= cz[a][i] + q2e_pkg::atan_entry(i);
        end else begin
          cx[a][i+1] <= cx[a][i] - dx;
          cy[a][i+1] <= cy[a][i] + dy;
          cz[a][i+1] <= cz[a][i] - q2e_pkg::atan_entry(i);
        end
      end
    end
  end

  // output stage: round to Q2.13 (roll, yaw) and Q1.13 (pitch) and clamp
  logic signed [ZW-1:0] ang_r, ang_y;
  logic signed [ZW:0]   ang_p;
  logic signed [ZW-7:0] rnd_r, rnd_y;
  logic signed [ZW-6:0] rnd_p;
  always_comb begin
    ang_r = czero[0][N] ? '0 : cz[0][N];
    ang_y = czero[2][N] ? '0 : cz[2][N];
    ang_p = ((czero[1][N] ? (ZW+1)'(0) : (ZW+1)'(cz[1][N])) <<< 1)
            - (ZW+1)'(q2e_pkg::HALF_PI_U);
    rnd_r = (ZW-6)'((ang_r + ZW'(64)) >>> 7);
    rnd_y = (ZW-6)'((ang_y + ZW'(64)) >>> 7);
    rnd_p = (ZW-5)'((ang_p + (ZW+1)'(64)) >>> 7);
  end

  always_ff @(posedge clk) begin
    priority if (rnd_r > q2e_pkg::ROLL_LIM) begin
      roll_angle <= 16'(q2e_pkg::ROLL_LIM);
    end else if (rnd_r < -q2e_pkg::ROLL_LIM) begin
      roll_angle <= 16'(-q2e_pkg::ROLL_LIM);
    end else begin
      roll_angle <= 16'(rnd_r);
    end
    priority if (rnd_y > q2e_pkg::ROLL_LIM) begin
      yaw_angle <= 16'(q2e_pkg::ROLL_LIM);
    end else if (rnd_y < -q2e_pkg::ROLL_LIM) begin
      yaw_angle <= 16'(-q2e_pkg::ROLL_LIM);
    end else begin
      yaw_angle <= 16'(rnd_y);
    end
    priority if (rnd_p > q2e_pkg::PITCH_LIM) begin
      pitch_angle <= 15'(q2e_pkg::PITCH_LIM);
    end else if (rnd_p < -q2e_pkg::PITCH_LIM) begin
      pitch_angle <= 15'(-q2e_pkg::PITCH_LIM);
    end else begin
      pitch_angle <= 15'(rnd_p);
    end
  end

endmodule

/* hw/rtl/q2e_checker.sv */
// Port-level checks for the quaternion to Euler core, bound to the top level.
// Depends on q2e_pkg and quaternion_to_euler_core_assert.svh.
`timescale 1ns / 1ps
`include "quaternion_to_euler_core_assert.svh"
module q2e_checker #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               strobe,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] yaw_angle
);

  localparam int N   = (CORDIC_STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN
                                                          : CORDIC_STEPS;
  localparam int LAT = N + q2e_pkg::FIXED_STAGES;

  // every accepted item comes out after the fixed latency
  `Q2E_ASSERT_IMP(a_latency, start && !busy, ##LAT strobe)
  // no result without an item taken in
  `Q2E_ASSERT_IMP(a_no_spurious, strobe, $past(start, LAT))
  // angles stay in their clamp ranges
  `Q2E_ASSERT_IMP(a_roll_yaw_range, strobe,
    roll_angle <= q2e_pkg::ROLL_LIM && roll_angle >= -q2e_pkg::ROLL_LIM &&
    yaw_angle <= q2e_pkg::ROLL_LIM && yaw_angle >= -q2e_pkg::ROLL_LIM)
  `Q2E_ASSERT_IMP(a_pitch_range, strobe,
    pitch_angle <= q2e_pkg::PITCH_LIM && pitch_angle >= -q2e_pkg::PITCH_LIM)

endmodule

bind quaternion_to_euler_core q2e_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_q2e_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
);

/* sim/testbench.sv */
// Testbench for quaternion_to_euler_core: directed and random quaternions.
// Depends on q2e_pkg and the core RTL; predicts angles with its own CORDIC model.
`timescale 1ns / 1ps
module testbench;

  localparam int STEPS   = q2e_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + q2e_pkg::FIXED_STAGES;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic               strobe;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  angles_t angle_queue[$];
  int      err_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      idle_pct = 0;

  quaternion_to_euler_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .strobe(strobe), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor shift on wide signed values
  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_units(input int i);
    longint t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? t[i] : 0;
  endfunction

  // vectoring CORDIC, angle in 2^-20 rad
  function automatic longint vector_angle(input longint yi, input longint xi);
    longint xv, yv, zv, t, dx, dy;
    int n;
    xv = xi; yv = yi; zv = 0;
    n = (STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN : STEPS;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; zv = q2e_pkg::HALF_PI_U;
      end else begin
        xv = -yv; yv = t; zv = -q2e_pkg::HALF_PI_U;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = asr(yv, i);
      dy = asr(xv, i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; zv += atan_units(i);
      end else begin
        xv -= dx; yv += dy; zv -= atan_units(i);
      end
    end
    return zv;
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r, b;
    r = 0; b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >>> 1) + b;
      end else r = r >>> 1;
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint to_fixed(input longint a, input longint lim);
    longint r;
    r = asr(a + 64, 7);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(input logic signed [15:0] w, x, y, z);
    longint lw, lx, ly, lz, sr, cr, sy, cy, s, one;
    angles_t a;
    lw = w; lx = x; ly = y; lz = z;
    one = 64'sd1 <<< 28;
    sr = 2 * (lw * lx + ly * lz);
    cr = one - 2 * (lx * lx + ly * ly);
    sy = 2 * (lw * lz + lx * ly);
    cy = one - 2 * (ly * ly + lz * lz);
    s  = 2 * (lw * ly - lx * lz);
    if (s > one) s = one;
    if (s < -one) s = -one;
    a.roll  = 16'(to_fixed(vector_angle(sr, cr), q2e_pkg::ROLL_LIM));
    a.pitch = 15'(to_fixed(2 * vector_angle(floor_sqrt(one + s), floor_sqrt(one - s))
                           - q2e_pkg::HALF_PI_U, q2e_pkg::PITCH_LIM));
    a.yaw   = 16'(to_fixed(vector_angle(sy, cy), q2e_pkg::ROLL_LIM));
    return a;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    err_count++;
  endtask

  // send one item, with random idle cycles before it; start stays high
  // until the next idle cycle or the end of the run
  task automatic send_quat(input logic signed [15:0] w, x, y, z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    angle_queue.push_back(euler_of(w, x, y, z));
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    angles_t e;
    if (!rst && strobe) begin
      results_seen++;
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = angle_queue.pop_front();
        if (roll_angle !== e.roll) report_mismatch("roll", roll_angle, e.roll);
        if (pitch_angle !== e.pitch) report_mismatch("pitch", pitch_angle, e.pitch);
        if (yaw_angle !== e.yaw) report_mismatch("yaw", yaw_angle, e.yaw);
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // extremes, axes, gimbal lock, zero and out-of-range
  task automatic test_directed();
    send_quat(16'sd16384, 0, 0, 0);
    send_quat(-16'sd16384, 0, 0, 0);
    send_quat(0, 16'sd16384, 0, 0);
    send_quat(0, 0, 16'sd16384, 0);
    send_quat(0, 0, 0, 16'sd16384);
    send_quat(0, 0, 0, -16'sd16384);
    send_quat(0, 0, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, -8192);
    send_quat(0, 11585, 0, -11585);
    send_quat(-1, -1, -1, -1);
    send_quat(1, 0, 0, 0);
  endtask

  // mostly near-unit quaternions, some raw 16-bit noise
  task automatic test_random(input int n);
    logic signed [15:0] c[4];
    real r, nrm;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 2) begin
        for (int k = 0; k < 4; k++) c[k] = 16'($urandom);
      end else begin
        nrm = 0.0;
        for (int k = 0; k < 4; k++) begin
          c[k] = rand_comp();
          nrm += real'(c[k]) * real'(c[k]);
        end
        if (nrm > 1.0) begin
          r = 16384.0 / $sqrt(nrm);
          for (int k = 0; k < 4; k++) c[k] = 16'($rtoi(real'(c[k]) * r));
        end
      end
      send_quat(c[0], c[1], c[2], c[3]);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 31;
    test_directed();
    test_random(640);
    idle_pct = 87;
    test_random(640);
    idle_pct = 0;
    test_random(650);
    start <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d quaternions (axes, gimbal lock, zero, overrange, random).",
             items_sent);
    $display("Checked %0d angle triples against the fixed-point CORDIC model.",
             results_seen);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
